// ===== src/spba_pkg.sv =====
package spba_pkg;

	localparam int SMALL_BLOCKS_D  = 80;
	localparam int MEDIUM_BLOCKS_D = 40;
	localparam int LARGE_BLOCKS_D  = 40;
	localparam int SMALL_SHIFT_D   = 6;
	localparam int MEDIUM_SHIFT_D  = 7;
	localparam int LARGE_SHIFT_D   = 8;

	// Registry index width covers three pools of up to 127 blocks each.
	localparam int REG_IDX_W = 9;
	localparam int RUN_W     = 7;
	localparam logic [7:0] RUN_CONT = 8'd255;

	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_NO_SPACE = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_MISALIGN = 3'd3;
	localparam logic [2:0] ST_FREED    = 3'd4;
	localparam logic [2:0] ST_MID_RUN  = 3'd5;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [23:0] request_bytes;
		logic [14:0] free_address;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [14:0] buffer_address;
		logic [1:0]  pool_id;
		logic [6:0]  block_count;
		logic [6:0]  used_small;
		logic [5:0]  used_medium;
		logic [5:0]  used_large;
	} rsp_t;

	// Decoded request: which pools an allocation may try, with the run
	// length for each, and where a free lands.
	typedef struct packed {
		logic [2:0]           try_pool;
		logic [RUN_W-1:0]     need_s;
		logic [RUN_W-1:0]     need_m;
		logic [RUN_W-1:0]     need_l;
		logic                 range_err;
		logic                 misaligned;
		logic [1:0]           free_pool;
		logic [REG_IDX_W-1:0] free_idx;
	} dec_t;

endpackage

// ===== src/spba_ram.sv =====
module spba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 160
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/spba_decode.sv =====
module spba_decode #(
	parameter int SMALL_BLOCKS  = spba_pkg::SMALL_BLOCKS_D,
	parameter int MEDIUM_BLOCKS = spba_pkg::MEDIUM_BLOCKS_D,
	parameter int LARGE_BLOCKS  = spba_pkg::LARGE_BLOCKS_D,
	parameter int SMALL_SHIFT   = spba_pkg::SMALL_SHIFT_D,
	parameter int MEDIUM_SHIFT  = spba_pkg::MEDIUM_SHIFT_D,
	parameter int LARGE_SHIFT   = spba_pkg::LARGE_SHIFT_D
) (
	input  spba_pkg::req_t req,
	output spba_pkg::dec_t dec
);
	import spba_pkg::*;

	localparam logic [31:0] BASE1 = 32'(SMALL_BLOCKS << SMALL_SHIFT);
	localparam logic [31:0] BASE2 = BASE1 + 32'(MEDIUM_BLOCKS << MEDIUM_SHIFT);
	localparam logic [31:0] BASE3 = BASE2 + 32'(LARGE_BLOCKS << LARGE_SHIFT);
	localparam logic [31:0] MASK_S = 32'((1 << SMALL_SHIFT) - 1);
	localparam logic [31:0] MASK_M = 32'((1 << MEDIUM_SHIFT) - 1);
	localparam logic [31:0] MASK_L = 32'((1 << LARGE_SHIFT) - 1);
	localparam logic [31:0] LIM_S = 32'(1 << SMALL_SHIFT);
	localparam logic [31:0] LIM_M = 32'(1 << MEDIUM_SHIFT);
	localparam logic [31:0] LIM_L = 32'(1 << LARGE_SHIFT);

	logic [31:0] bytes, fa, rel;
	logic [31:0] nd_s, nd_m, nd_l;

	always_comb begin
		bytes = 32'(req.request_bytes);
		nd_s = (bytes >> SMALL_SHIFT) + 32'(|(bytes & MASK_S));
		nd_m = (bytes >> MEDIUM_SHIFT) + 32'(|(bytes & MASK_M));
		nd_l = (bytes >> LARGE_SHIFT) + 32'(|(bytes & MASK_L));
		dec.need_s = '0;
		dec.need_m = '0;
		dec.need_l = '0;
		dec.try_pool = '0;
		if (bytes <= LIM_S) begin
			dec.try_pool = 3'b001;
			dec.need_s = RUN_W'(1);
		end else if (bytes <= LIM_M) begin
			dec.try_pool = 3'b010;
			dec.need_m = RUN_W'(1);
		end else if (bytes <= LIM_L) begin
			dec.try_pool = 3'b100;
			dec.need_l = RUN_W'(1);
		end else begin
			dec.need_s = nd_s[RUN_W-1:0];
			dec.need_m = nd_m[RUN_W-1:0];
			dec.need_l = nd_l[RUN_W-1:0];
			dec.try_pool[0] = (nd_s != 0) && (nd_s <= 32'(SMALL_BLOCKS));
			dec.try_pool[1] = (nd_m != 0) && (nd_m <= 32'(MEDIUM_BLOCKS));
			dec.try_pool[2] = (nd_l != 0) && (nd_l <= 32'(LARGE_BLOCKS));
		end

		fa = 32'(req.free_address);
		dec.range_err = 1'b0;
		dec.misaligned = 1'b0;
		dec.free_pool = 2'd0;
		dec.free_idx = '0;
		rel = '0;
		if (fa < BASE1) begin
			rel = fa;
			dec.misaligned = |(rel & MASK_S);
			dec.free_idx = REG_IDX_W'(rel >> SMALL_SHIFT);
		end else if (fa < BASE2) begin
			rel = fa - BASE1;
			dec.free_pool = 2'd1;
			dec.misaligned = |(rel & MASK_M);
			dec.free_idx = REG_IDX_W'((rel >> MEDIUM_SHIFT) + 32'(SMALL_BLOCKS));
		end else if (fa < BASE3) begin
			rel = fa - BASE2;
			dec.free_pool = 2'd2;
			dec.misaligned = |(rel & MASK_L);
			dec.free_idx = REG_IDX_W'((rel >> LARGE_SHIFT)
				+ 32'(SMALL_BLOCKS + MEDIUM_BLOCKS));
		end else begin
			dec.range_err = 1'b1;
		end
	end
endmodule

// ===== src/segregated_pool_block_allocator.sv =====
// Block allocator over three pools of small, medium and large blocks. Pulse
// start while busy is low to hand in one request word; exactly one result
// word follows on result, marked by done for one cycle, and it must be taken
// then because the receiver cannot stall. One registry memory, read one
// entry at a time by a single scan sequencer, does all the work. An
// allocation scans from the pool's next-fit cursor over up to twice the
// pool size in registry entries per pool tried, then writes one entry per
// block. A free checks the head entry and clears one entry per block
// released. Registry valid flags clear at reset, so no clearing pass is run.
module segregated_pool_block_allocator #(
	parameter int SMALL_BLOCKS  = spba_pkg::SMALL_BLOCKS_D,
	parameter int MEDIUM_BLOCKS = spba_pkg::MEDIUM_BLOCKS_D,
	parameter int LARGE_BLOCKS  = spba_pkg::LARGE_BLOCKS_D,
	parameter int SMALL_SHIFT   = spba_pkg::SMALL_SHIFT_D,
	parameter int MEDIUM_SHIFT  = spba_pkg::MEDIUM_SHIFT_D,
	parameter int LARGE_SHIFT   = spba_pkg::LARGE_SHIFT_D
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  spba_pkg::req_t req,
	output logic           done,
	output spba_pkg::rsp_t result
);
	import spba_pkg::*;

	localparam int TOTAL = SMALL_BLOCKS + MEDIUM_BLOCKS + LARGE_BLOCKS;
	localparam int AW = $clog2(TOTAL);
	localparam logic [REG_IDX_W-1:0] FIRST_M = REG_IDX_W'(SMALL_BLOCKS);
	localparam logic [REG_IDX_W-1:0] FIRST_L = REG_IDX_W'(SMALL_BLOCKS + MEDIUM_BLOCKS);
	localparam logic [REG_IDX_W-1:0] END_S = FIRST_M;
	localparam logic [REG_IDX_W-1:0] END_M = FIRST_L;
	localparam logic [REG_IDX_W-1:0] END_L = REG_IDX_W'(TOTAL);
	localparam logic [REG_IDX_W-1:0] LAST_IDX = REG_IDX_W'(TOTAL - 1);
	localparam logic [31:0] BASE_M = 32'(SMALL_BLOCKS << SMALL_SHIFT);
	localparam logic [31:0] BASE_L = BASE_M + 32'(MEDIUM_BLOCKS << MEDIUM_SHIFT);

	typedef enum logic [2:0] {
		IDLE, PICK, SCAN_RD, SCAN_CHK, FILL, FREE_DEC, FREE_CHK, CLEAR
	} state_t;

	state_t               state_q;
	req_t                 req_q;
	dec_t                 dec;
	logic [1:0]           pool_q;
	logic [REG_IDX_W-1:0] pos_q, s_q, rd_idx_q;
	logic [RUN_W-1:0]     len_q, n_q;
	logic                 wrap_q;
	logic [REG_IDX_W-1:0] cur_q [3];
	logic [RUN_W-1:0]     used_q [3];
	logic [TOTAL-1:0]     valid_q;
	logic [2:0]           st_q;
	logic [14:0]          addr_q;
	logic [1:0]           pid_q;
	logic [6:0]           cnt_q;
	logic                 done_q;

	logic                 we;
	logic [REG_IDX_W-1:0] waddr, raddr;
	logic [7:0]           wdata, rdata, entry;
	logic [REG_IDX_W-1:0] p_first, p_end, p_cur, nxt, e_idx;
	logic [RUN_W-1:0]     p_need, used_sel;
	logic [31:0]          run_addr;

	spba_decode #(
		.SMALL_BLOCKS(SMALL_BLOCKS), .MEDIUM_BLOCKS(MEDIUM_BLOCKS),
		.LARGE_BLOCKS(LARGE_BLOCKS), .SMALL_SHIFT(SMALL_SHIFT),
		.MEDIUM_SHIFT(MEDIUM_SHIFT), .LARGE_SHIFT(LARGE_SHIFT)
	) u_decode (
		.req(req_q),
		.dec(dec)
	);

	spba_ram #(.WIDTH(8), .DEPTH(TOTAL)) u_registry (
		.clk(clk),
		.we(we),
		.waddr(waddr[AW-1:0]),
		.wdata(wdata),
		.raddr(raddr[AW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		case (pool_q)
			2'd0: begin
				p_first = '0; p_end = END_S; p_need = dec.need_s;
				run_addr = 32'(s_q) << SMALL_SHIFT;
			end
			2'd1: begin
				p_first = FIRST_M; p_end = END_M; p_need = dec.need_m;
				run_addr = BASE_M + (32'(s_q - FIRST_M) << MEDIUM_SHIFT);
			end
			default: begin
				p_first = FIRST_L; p_end = END_L; p_need = dec.need_l;
				run_addr = BASE_L + (32'(s_q - FIRST_L) << LARGE_SHIFT);
			end
		endcase
		p_cur = cur_q[pool_q];
		used_sel = used_q[pool_q];
		nxt = pos_q + 1'b1;
		e_idx = s_q + REG_IDX_W'(n_q);
		if (e_idx >= p_end) begin
			e_idx = p_first;
		end
		// Entries never written since reset read as free.
		entry = valid_q[rd_idx_q[AW-1:0]] ? rdata : 8'd0;
		raddr = (state_q == FREE_DEC) ? dec.free_idx : pos_q;
		we = (state_q == FILL) || (state_q == CLEAR);
		waddr = pos_q;
		if (state_q == CLEAR) begin
			wdata = 8'd0;
		end else if (len_q == '0) begin
			wdata = 8'(n_q);
		end else begin
			wdata = RUN_CONT;
		end
	end

	assign busy = (state_q != IDLE);
	assign done = done_q;
	always_comb begin
		result.status = st_q;
		result.buffer_address = addr_q;
		result.pool_id = pid_q;
		result.block_count = cnt_q;
		result.used_small = used_q[0];
		result.used_medium = used_q[1][5:0];
		result.used_large = used_q[2][5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done_q <= 1'b0;
			valid_q <= '0;
			cur_q[0] <= '0;
			cur_q[1] <= FIRST_M;
			cur_q[2] <= FIRST_L;
			used_q[0] <= '0;
			used_q[1] <= '0;
			used_q[2] <= '0;
			pool_q <= 2'd2;
			wrap_q <= 1'b0;
			req_q <= '0;
			pos_q <= '0;
			s_q <= '0;
			rd_idx_q <= '0;
			len_q <= '0;
			n_q <= '0;
			st_q <= ST_DONE;
			addr_q <= '0;
			pid_q <= '0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			rd_idx_q <= raddr;
			if (we) begin
				valid_q[pos_q[AW-1:0]] <= 1'b1;
			end
			case (state_q)
				IDLE: begin
					if (start) begin
						req_q <= req;
						pool_q <= 2'd2;
						state_q <= (req.opcode == OP_FREE) ? FREE_DEC : PICK;
					end
				end
				PICK: begin
					if (dec.try_pool[pool_q]) begin
						n_q <= p_need;
						pos_q <= p_cur;
						s_q <= p_cur;
						len_q <= '0;
						wrap_q <= 1'b0;
						state_q <= SCAN_RD;
					end else if (pool_q == 2'd0) begin
						st_q <= ST_NO_SPACE; addr_q <= '0; pid_q <= '0; cnt_q <= '0;
						done_q <= 1'b1;
						state_q <= IDLE;
					end else begin
						pool_q <= pool_q - 2'd1;
					end
				end
				SCAN_RD: begin
					state_q <= SCAN_CHK;
				end
				SCAN_CHK: begin
					if (entry == 8'd0 && len_q + 1'b1 == n_q) begin
						pos_q <= s_q;
						len_q <= '0;
						state_q <= FILL;
					end else begin
						state_q <= SCAN_RD;
						if (entry == 8'd0) begin
							len_q <= len_q + 1'b1;
						end else begin
							len_q <= '0;
							s_q <= nxt;
						end
						// A start at or past the cursor after the wrap was already tried.
						if ((nxt == p_end && (wrap_q || p_cur == p_first))
							|| (entry != 8'd0 && wrap_q && nxt >= p_cur)) begin
							state_q <= PICK;
							if (pool_q == 2'd0) begin
								st_q <= ST_NO_SPACE; addr_q <= '0; pid_q <= '0;
								cnt_q <= '0;
								done_q <= 1'b1;
								state_q <= IDLE;
							end else begin
								pool_q <= pool_q - 2'd1;
							end
						end else if (nxt == p_end) begin
							wrap_q <= 1'b1;
							pos_q <= p_first;
							s_q <= p_first;
							len_q <= '0;
						end else begin
							pos_q <= nxt;
						end
					end
				end
				FILL: begin
					pos_q <= nxt;
					len_q <= len_q + 1'b1;
					if (len_q + 1'b1 == n_q) begin
						cur_q[pool_q] <= e_idx;
						used_q[pool_q] <= used_sel + n_q;
						st_q <= ST_DONE;
						addr_q <= run_addr[14:0];
						pid_q <= pool_q;
						cnt_q <= n_q;
						done_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				FREE_DEC: begin
					addr_q <= '0;
					cnt_q <= '0;
					pid_q <= dec.free_pool;
					pos_q <= dec.free_idx;
					pool_q <= dec.free_pool;
					if (dec.range_err) begin
						st_q <= ST_RANGE;
						pid_q <= '0;
						done_q <= 1'b1;
						state_q <= IDLE;
					end else if (dec.misaligned) begin
						st_q <= ST_MISALIGN;
						done_q <= 1'b1;
						state_q <= IDLE;
					end else begin
						state_q <= FREE_CHK;
					end
				end
				FREE_CHK: begin
					if (entry == 8'd0) begin
						st_q <= ST_FREED;
						done_q <= 1'b1;
						state_q <= IDLE;
					end else if (entry == RUN_CONT) begin
						st_q <= ST_MID_RUN;
						done_q <= 1'b1;
						state_q <= IDLE;
					end else begin
						n_q <= entry[RUN_W-1:0];
						len_q <= '0;
						state_q <= CLEAR;
					end
				end
				CLEAR: begin
					pos_q <= nxt;
					len_q <= len_q + 1'b1;
					if (len_q + 1'b1 == n_q || pos_q == LAST_IDX) begin
						used_q[pool_q] <= (used_sel >= n_q) ? used_sel - n_q : '0;
						st_q <= ST_DONE;
						cnt_q <= n_q;
						done_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end
endmodule

// ===== bench/testbench.sv =====
module testbench;
	import spba_pkg::*;

	localparam int N_SMALL  = SMALL_BLOCKS_D;
	localparam int N_MEDIUM = MEDIUM_BLOCKS_D;
	localparam int N_LARGE  = LARGE_BLOCKS_D;
	localparam int N_TOTAL  = N_SMALL + N_MEDIUM + N_LARGE;
	localparam int IDLE_NONE = 0;
	localparam int IDLE_HEAVY = 78;
	localparam int IDLE_LIGHT = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	req_t req = '0;
	rsp_t result;

	int unsigned shift_of [3] = '{SMALL_SHIFT_D, MEDIUM_SHIFT_D, LARGE_SHIFT_D};
	int unsigned blocks_of [3] = '{N_SMALL, N_MEDIUM, N_LARGE};
	int unsigned first_of [3] = '{0, N_SMALL, N_SMALL + N_MEDIUM};

	logic [7:0] registry [N_TOTAL] = '{default: 8'd0};
	int unsigned cursor [3] = '{0, N_SMALL, N_SMALL + N_MEDIUM};
	int unsigned used [3];
	int unsigned idle_pct;

	rsp_t expected_rsp [$];
	int mismatches = 0;
	bit failed = 1'b0;

	// Addresses of live runs so that most frees hit real buffers.
	logic [14:0] live_addr [$];

	segregated_pool_block_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int unsigned byte_base(input int unsigned p);
		int unsigned b;
		b = 0;
		for (int k = 0; k < p; k++) b += blocks_of[k] << shift_of[k];
		return b;
	endfunction

	function automatic bit claim_run(input int unsigned n, input int unsigned p,
			output int unsigned addr);
		int unsigned last, i;
		bit clear;
		last = first_of[p] + blocks_of[p];
		addr = 0;
		if (n == 0 || n > blocks_of[p]) return 1'b0;
		for (int unsigned s = 0; s < blocks_of[p]; s++) begin
			i = cursor[p] + s;
			if (i >= last) i -= blocks_of[p];
			if (i + n > last) continue;
			clear = 1'b1;
			for (int unsigned e = i; e < i + n; e++)
				if (registry[e] != 0) clear = 1'b0;
			if (!clear) continue;
			registry[i] = n[7:0];
			for (int unsigned e = i + 1; e < i + n; e++) registry[e] = RUN_CONT;
			cursor[p] = (i + n >= last) ? i + n - blocks_of[p] : i + n;
			used[p] += n;
			addr = byte_base(p) + ((i - first_of[p]) << shift_of[p]);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic rsp_t predict_allocator(input req_t r);
		rsp_t o;
		int unsigned bytes, addr, pid, cnt, need, p, rel, idx, mb;
		bit ok;
		o = '0;
		addr = 0; pid = 0; cnt = 0;
		if (r.opcode == OP_ALLOC) begin
			bytes = r.request_bytes;
			ok = 1'b0;
			if (bytes <= (1 << SMALL_SHIFT_D)) begin
				pid = 0; cnt = 1; ok = claim_run(1, 0, addr);
			end else if (bytes <= (1 << MEDIUM_SHIFT_D)) begin
				pid = 1; cnt = 1; ok = claim_run(1, 1, addr);
			end else if (bytes <= (1 << LARGE_SHIFT_D)) begin
				pid = 2; cnt = 1; ok = claim_run(1, 2, addr);
			end else begin
				for (int k = 2; k >= 0 && !ok; k--) begin
					need = (bytes >> shift_of[k]) +
						(((bytes & ((1 << shift_of[k]) - 1)) != 0) ? 1 : 0);
					pid = k; cnt = need;
					if (need <= 255) ok = claim_run(need, k, addr);
				end
			end
			if (!ok) begin
				o.status = ST_NO_SPACE; addr = 0; pid = 0; cnt = 0;
			end else begin
				o.status = ST_DONE;
				live_addr.push_back(addr[14:0]);
			end
		end else begin
			p = 3;
			for (int k = 2; k >= 0; k--)
				if (r.free_address < byte_base(k + 1)) p = k;
			if (p == 3) begin
				o.status = ST_RANGE;
			end else begin
				pid = p;
				rel = r.free_address - byte_base(p);
				if ((rel & ((1 << shift_of[p]) - 1)) != 0) begin
					o.status = ST_MISALIGN;
				end else begin
					idx = (rel >> shift_of[p]) + first_of[p];
					mb = (idx < N_TOTAL) ? registry[idx] : 0;
					if (mb == 0) o.status = ST_FREED;
					else if (mb == RUN_CONT) o.status = ST_MID_RUN;
					else begin
						o.status = ST_DONE;
						for (int unsigned e = idx; e < idx + mb && e < N_TOTAL; e++)
							registry[e] = 0;
						used[p] = (used[p] >= mb) ? used[p] - mb : 0;
						cnt = mb;
					end
				end
			end
		end
		o.buffer_address = addr[14:0];
		o.pool_id = pid[1:0];
		o.block_count = cnt[6:0];
		o.used_small = used[0][6:0];
		o.used_medium = used[1][5:0];
		o.used_large = used[2][5:0];
		return o;
	endfunction

	// One request word: optional idle gap, then hold start until accepted.
	// Start stays high after acceptance until the next gap or the end of the run.
	task automatic send_request(input logic op, input logic [23:0] bytes,
			input logic [14:0] faddr);
		req_t r;
		r.opcode = op;
		r.request_bytes = bytes;
		r.free_address = faddr;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_rsp.push_back(predict_allocator(r));
	endtask

	task automatic send_free_live();
		int k;
		if (live_addr.size() == 0) begin
			send_request(OP_FREE, '0, 15'd0);
			return;
		end
		k = $urandom_range(live_addr.size() - 1);
		send_request(OP_FREE, 24'($urandom), live_addr[k]);
		live_addr.delete(k);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %p", result);
			end else begin
				rsp_t x;
				x = expected_rsp.pop_front();
				if (result !== x) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", x, result);
				end
			end
		end
	end

	task automatic test_directed();
		send_request(OP_ALLOC, 24'd0, '0);
		send_request(OP_ALLOC, 24'd64, '0);
		send_request(OP_ALLOC, 24'd65, '0);
		send_request(OP_ALLOC, 24'd128, '0);
		send_request(OP_ALLOC, 24'd129, '0);
		send_request(OP_ALLOC, 24'd256, '0);
		send_request(OP_ALLOC, 24'd257, '0);
		send_request(OP_ALLOC, 24'd10240, '0);
		send_request(OP_ALLOC, 24'd10241, '0);
		send_request(OP_ALLOC, 24'hFFFFFF, '0);
		send_request(OP_FREE, '0, 15'h7FFF);
		send_request(OP_FREE, '0, 15'd20480);
		send_request(OP_FREE, '0, 15'd1);
		send_request(OP_FREE, '0, 15'd5120 + 15'd1);
		send_request(OP_FREE, '0, 15'd10240 + 15'd255);
		send_request(OP_FREE, '0, 15'd4096);
		// The two-block run in the large pool: its second block is mid-run.
		send_request(OP_FREE, '0, 15'd10240 + 15'd768);
		send_request(OP_FREE, '0, 15'd64);
		send_request(OP_FREE, '0, 15'd64);
		while (live_addr.size() > 0) send_free_live();
	endtask

	// Fill a pool to failure so the wrap and full cases are reached.
	task automatic test_fill_and_drain();
		for (int i = 0; i < 45; i++) send_request(OP_ALLOC, 24'd200, '0);
		for (int i = 0; i < 20; i++) send_free_live();
		for (int i = 0; i < 10; i++)
			send_request(OP_ALLOC, 24'($urandom_range(129, 256)), '0);
		while (live_addr.size() > 0) send_free_live();
	endtask

	task automatic test_random(input int n);
		int unsigned sel;
		logic [23:0] b;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 45) begin
				case ($urandom_range(4))
					0: b = 24'($urandom_range(64));
					1: b = 24'($urandom_range(65, 128));
					2: b = 24'($urandom_range(129, 256));
					3: b = 24'($urandom_range(257, 3000));
					default: b = 24'($urandom);
				endcase
				send_request(OP_ALLOC, b, 15'($urandom));
			end else if (sel < 85) begin
				send_free_live();
			end else begin
				send_request(OP_FREE, 24'($urandom), 15'($urandom));
			end
		end
	endtask

	initial begin
		idle_pct = IDLE_NONE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_and_drain();
		test_random(120);
		idle_pct = IDLE_HEAVY;
		test_random(120);
		idle_pct = IDLE_LIGHT;
		test_random(120);
		idle_pct = IDLE_NONE;
		test_random(60);
		start <= 1'b0;
		while (expected_rsp.size() > 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (!failed && expected_rsp.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/spba_pkg.sv
src/spba_ram.sv
src/spba_decode.sv
src/segregated_pool_block_allocator.sv
bench/testbench.sv
